// ===== src/irs_pkg.sv =====
// Shared types, constants and codes for the indentation rescaler.
// Used by every module of the block; depends on nothing.
package irs_pkg;

	localparam int BYTE_W         = 8;
	localparam int COL_W          = 8;
	localparam int PROD_W         = 2 * COL_W;
	localparam int DIV_STEPS      = PROD_W;
	localparam int STEP_W         = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W      = 1;
	localparam int MAX_COLUMN_DEF = 255;
	localparam int FIFO_DEPTH_DEF = 4;

	localparam logic [COL_W-1:0]  TAB_WIDTH  = COL_W'(8);
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

	localparam logic [CFG_IDX_W-1:0] REG_OLD_STEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_STEP = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_item_t;

	// Queue entry: either a plain pass-through byte or an indentation job
	typedef struct packed {
		logic              indent;
		logic              has_data;
		logic [COL_W-1:0]  col;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_EMIT  = 5'b10000
	} back_state_t;

endpackage

// ===== src/indentation_rescaler.sv =====
// Indentation rescaler: line-body bytes pass through queue and output register at
// one per cycle while the output is not stalled. A line start runs through queue,
// pop, multiply, 16-step divider (one quotient bit per cycle), round and first load,
// then emits further tabs, spaces or its byte at one per cycle unless stalled.
// Reset (arst_n low, asynchronous) returns to line start with zero columns, empties
// the queue and output register, and sets both scale step registers to 1.
module indentation_rescaler #(
	parameter int MAX_COLUMN = irs_pkg::MAX_COLUMN_DEF,
	parameter int FIFO_DEPTH = irs_pkg::FIFO_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  irs_pkg::in_item_t             src_item,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output irs_pkg::out_item_t            dst_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [irs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irs_pkg::COL_W-1:0]     cfg_data
);
	import irs_pkg::*;

	logic [COL_W-1:0] old_step_q;
	logic [COL_W-1:0] new_step_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	cmd_t             push_cmd;
	cmd_t             head_cmd;

	// Configuration transactions are always taken; the user must write only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_step_q <= COL_W'(1);
			new_step_q <= COL_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OLD_STEP: old_step_q <= cfg_data;
				REG_NEW_STEP: new_step_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: classify each byte, count leading columns, push commands.
	irs_front #(
		.MAX_COLUMN(MAX_COLUMN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// Queue: decouple the byte-rate front from the bursty back end.
	irs_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (head_cmd)
	);

	// Back: pass bytes through or scale and expand indentation.
	irs_back #(
		.MAX_COLUMN(MAX_COLUMN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.old_step (old_step_q),
		.new_step (new_step_q),
		.q_empty  (q_empty),
		.q_head   (head_cmd),
		.q_pop    (q_pop),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item)
	);

endmodule

// ===== src/irs_front.sv =====
// Front end: accepts text bytes, tracks line state and indentation columns.
// Pushes pass-through and indentation commands; depends on irs_pkg.
module irs_front #(
	parameter int MAX_COLUMN = irs_pkg::MAX_COLUMN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  irs_pkg::in_item_t src_item,
	input  logic              q_full,
	output logic              q_push,
	output irs_pkg::cmd_t     q_cmd
);
	import irs_pkg::*;

	logic             body_q;
	logic [COL_W-1:0] col_q;
	logic             body_nx;
	logic [COL_W-1:0] col_nx;
	logic             accept;
	logic             want_push;
	logic [COL_W:0]   col_sum;

	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;
	assign q_push    = accept && want_push;

	always_comb begin
		body_nx        = body_q;
		col_nx         = col_q;
		want_push      = 1'b0;
		col_sum        = '0;
		q_cmd.indent   = 1'b0;
		q_cmd.has_data = 1'b0;
		q_cmd.col      = col_q;
		q_cmd.data     = src_item.in_byte;
		if (src_item.end_of_input) begin
			want_push    = !body_q;
			q_cmd.indent = 1'b1;
			body_nx      = 1'b0;
			col_nx       = '0;
		end else if (body_q) begin
			want_push = 1'b1;
			if (src_item.in_byte == CH_NEWLINE) begin
				body_nx = 1'b0;
				col_nx  = '0;
			end
		end else if (src_item.in_byte == CH_SPACE) begin
			col_sum = {1'b0, col_q} + (COL_W+1)'(1);
			col_nx  = (col_sum > (COL_W+1)'(MAX_COLUMN)) ? COL_W'(MAX_COLUMN) : col_sum[COL_W-1:0];
		end else if (src_item.in_byte == CH_TAB) begin
			// advance to the next tab stop
			col_sum = ({1'b0, col_q} + {1'b0, TAB_WIDTH}) & ~(COL_W+1)'(TAB_WIDTH - 1'b1);
			col_nx  = (col_sum > (COL_W+1)'(MAX_COLUMN)) ? COL_W'(MAX_COLUMN) : col_sum[COL_W-1:0];
		end else begin
			want_push      = 1'b1;
			q_cmd.indent   = 1'b1;
			q_cmd.has_data = 1'b1;
			col_nx         = '0;
			body_nx        = (src_item.in_byte != CH_NEWLINE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q <= 1'b0;
			col_q  <= '0;
		end else if (accept) begin
			body_q <= body_nx;
			col_q  <= col_nx;
		end
	end

	prop_col_limit: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(MAX_COLUMN))
		else $error("column count above limit");

	prop_body_clear: assert property (@(posedge clk) disable iff (!arst_n)
		body_q |-> col_q == '0)
		else $error("column count left over inside a line body");

	prop_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full && src_valid)
		else $error("command pushed without an accepted transaction");

endmodule

// ===== src/irs_fifo.sv =====
// Short command queue between front and back end.
// Register-based storage with a fill count; depends on irs_pkg.
module irs_fifo #(
	parameter int DEPTH = irs_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  irs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output irs_pkg::cmd_t head
);
	import irs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	prop_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	prop_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

	prop_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above queue depth");

endmodule

// ===== src/irs_back.sv =====
// Back end: runs queued commands, scales indentation with a shift-subtract
// divider and emits tabs, spaces and bytes; depends on irs_pkg.
module irs_back #(
	parameter int MAX_COLUMN = irs_pkg::MAX_COLUMN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [irs_pkg::COL_W-1:0]  old_step,
	input  logic [irs_pkg::COL_W-1:0]  new_step,
	input  logic                       q_empty,
	input  irs_pkg::cmd_t              q_head,
	output logic                       q_pop,
	output logic                       dst_valid,
	input  logic                       dst_stall,
	output irs_pkg::out_item_t         dst_item
);
	import irs_pkg::*;

	back_state_t       state_q;
	logic [COL_W-1:0]  col_q;
	logic [BYTE_W-1:0] data_q;
	logic              has_data_q;
	logic [PROD_W-1:0] quo_q;
	logic [COL_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [COL_W-1:0]  cols_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic [COL_W-1:0]  divisor;
	logic [COL_W:0]    rem_sh;
	logic              sub_ok;
	logic              round_up;
	logic [PROD_W:0]   q_sum;
	logic              slot_free;
	logic              load;
	out_item_t         load_item;

	assign divisor   = (old_step == '0) ? COL_W'(1) : old_step;
	assign rem_sh    = {rem_q, quo_q[PROD_W-1]};
	assign sub_ok    = (rem_sh >= {1'b0, divisor});
	assign round_up  = ({rem_q, 1'b0} > {1'b0, divisor});
	assign q_sum     = {1'b0, quo_q} + (PROD_W+1)'(round_up);
	assign slot_free = !out_valid_q || !dst_stall;
	assign dst_valid = out_valid_q;
	assign dst_item  = out_item_q;

	always_comb begin
		q_pop     = 1'b0;
		load      = 1'b0;
		load_item = '{out_byte: q_head.data, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_head.indent) begin
						q_pop = 1'b1;
					end else if (slot_free) begin
						q_pop = 1'b1;
						load  = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (cols_q >= TAB_WIDTH) begin
						load      = 1'b1;
						load_item = '{out_byte: CH_TAB, last: (cols_q == TAB_WIDTH) && !has_data_q};
					end else if (cols_q != '0) begin
						load      = 1'b1;
						load_item = '{out_byte: CH_SPACE,
							last: (cols_q == COL_W'(1)) && !has_data_q};
					end else if (has_data_q) begin
						load      = 1'b1;
						load_item = '{out_byte: data_q, last: 1'b1};
					end
				end
			end
			ST_MUL, ST_DIV, ST_ROUND: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty && q_head.indent) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// leave once the final column and the trailing byte are out
					if (slot_free && cols_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				col_q      <= q_head.col;
				data_q     <= q_head.data;
				has_data_q <= q_head.has_data;
			end
			ST_MUL: begin
				quo_q <= PROD_W'(col_q) * PROD_W'(new_step);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= sub_ok ? COL_W'(rem_sh - {1'b0, divisor}) : rem_sh[COL_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], sub_ok};
			end
			ST_ROUND: begin
				cols_q <= (q_sum > (PROD_W+1)'(MAX_COLUMN)) ? COL_W'(MAX_COLUMN)
					: q_sum[COL_W-1:0];
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (cols_q >= TAB_WIDTH) begin
						cols_q <= cols_q - TAB_WIDTH;
					end else if (cols_q != '0) begin
						cols_q <= cols_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= load_item;
		end
	end

	prop_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == STEP_W'(DIV_STEPS - 1)) |=> state_q == ST_ROUND)
		else $error("divider did not finish after its last step");

	prop_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> cols_q <= COL_W'(MAX_COLUMN))
		else $error("emitted column count above limit");

	prop_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dst_stall) |-> !load)
		else $error("stalled output overwritten");

endmodule

// ===== tb/indentation_rescaler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for indentation_rescaler.
// Depends on irs_pkg for payload types, byte codes and register indexes.
module indentation_rescaler_tb;
	import irs_pkg::*;

	localparam int MAX_COL     = MAX_COLUMN_DEF;
	localparam int TAB_W       = int'(TAB_WIDTH);
	localparam int DRAIN_TAIL  = 160;      // covers a full queue of silent indentation jobs
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 104;      // random items per idling phase

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	logic               src_stall;
	in_item_t           src_item;
	logic               dst_valid;
	logic               dst_stall = 1'b0;
	out_item_t          dst_item;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COL_W-1:0]   cfg_data;

	// Own copy of the block state and registers
	int old_step;
	int new_step;
	bit in_body;
	int col_cnt;

	out_item_t out_bytes_due[$];   // bytes the block still owes, oldest first
	int        mismatches;
	int        cycle_cnt = 0;
	int        src_idle_pct;
	int        dst_stall_pct;

	indentation_rescaler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Bound the run; a hung handshake ends here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver back-pressure: redraw the stall at every falling edge
	always @(negedge clk) begin
		dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);
	end

	// Scale the pending indentation: round to nearest, a tie rounds down,
	// a zero divisor acts as one, saturate at the column limit.
	function automatic int scaled_columns();
		int div;
		int prod;
		int quo;
		int rem;
		div  = (old_step == 0) ? 1 : old_step;
		prod = col_cnt * new_step;
		quo  = prod / div;
		rem  = prod % div;
		if (2 * rem > div)
			quo++;
		if (quo > MAX_COL)
			quo = MAX_COL;
		return quo;
	endfunction

	// Work out what one accepted input transaction makes the block emit
	task automatic predict_rescale(input in_item_t it);
		out_item_t res[$];
		out_item_t one;
		int        cols;
		one.last = 1'b0;
		cols = 0;
		if (it.end_of_input) begin
			if (!in_body)
				cols = scaled_columns();
			in_body = 1'b0;
			col_cnt = 0;
		end else if (in_body) begin
			cols = -1;
			if (it.in_byte == CH_NEWLINE) begin
				in_body = 1'b0;
				col_cnt = 0;
			end
		end else if (it.in_byte == CH_SPACE) begin
			col_cnt = (col_cnt + 1 > MAX_COL) ? MAX_COL : col_cnt + 1;
		end else if (it.in_byte == CH_TAB) begin
			col_cnt = ((col_cnt + TAB_W) / TAB_W) * TAB_W;
			if (col_cnt > MAX_COL)
				col_cnt = MAX_COL;
		end else begin
			cols = scaled_columns();
			col_cnt = 0;
			in_body = (it.in_byte != CH_NEWLINE);
			// Emit the indentation below, then the byte itself
			while (cols >= TAB_W) begin
				one.out_byte = CH_TAB;
				res.push_back(one);
				cols -= TAB_W;
			end
			while (cols > 0) begin
				one.out_byte = CH_SPACE;
				res.push_back(one);
				cols--;
			end
			cols = -1;
		end
		// Indentation alone (end of input at line start)
		if (cols > 0) begin
			while (cols >= TAB_W) begin
				one.out_byte = CH_TAB;
				res.push_back(one);
				cols -= TAB_W;
			end
			while (cols > 0) begin
				one.out_byte = CH_SPACE;
				res.push_back(one);
				cols--;
			end
		end else if (cols < 0) begin
			one.out_byte = it.in_byte;
			res.push_back(one);
		end
		if (res.size() > 0)
			res[res.size()-1].last = 1'b1;
		foreach (res[i])
			out_bytes_due.push_back(res[i]);
	endtask

	// Check every output transaction against the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (out_bytes_due.size() == 0) begin
				$display("%0t: unexpected output, expected none, actual byte %02h last %0b",
					$time, dst_item.out_byte, dst_item.last);
				mismatches++;
			end else begin
				if (dst_item.out_byte !== out_bytes_due[0].out_byte) begin
					$display("%0t: out_byte mismatch, expected %02h, actual %02h",
						$time, out_bytes_due[0].out_byte, dst_item.out_byte);
					mismatches++;
				end
				if (dst_item.last !== out_bytes_due[0].last) begin
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, out_bytes_due[0].last, dst_item.last);
					mismatches++;
				end
				void'(out_bytes_due.pop_front());
			end
		end
	end

	// Present one input transaction; hold it until accepted, then predict.
	// Valid stays high on return, so the next call or a drain must follow.
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic eoi);
		in_item_t it;
		it.in_byte      = b;
		it.end_of_input = eoi;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do
			@(posedge clk);
		while (src_stall);
		predict_rescale(it);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(b, 1'b0);
	endtask

	// Drop valid, wait for every expected byte, then let the back end settle
	task automatic wait_drain();
		@(negedge clk);
		src_valid <= 1'b0;
		while (out_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Write one register; call only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_OLD_STEP)
			old_step = int'(val);
		else
			new_step = int'(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_scale(input int old_val, input int new_val);
		wait_drain();
		write_reg(REG_OLD_STEP, old_val[COL_W-1:0]);
		write_reg(REG_NEW_STEP, new_val[COL_W-1:0]);
	endtask

	// Reset scale: indentation passes through, extreme byte values in body and at line start
	task automatic test_pass_through();
		send_byte(CH_SPACE);
		send_byte(CH_SPACE);
		send_byte("a");
		send_byte(8'hFF);
		send_byte(CH_NEWLINE);
		send_byte(8'h00);
		send_byte(CH_NEWLINE);
		wait_drain();
	endtask

	// Newline at line start: emit indentation and newline, stay at line start
	task automatic test_start_newline();
		send_byte(CH_TAB);
		send_byte(CH_NEWLINE);
		send_byte(CH_SPACE);
		send_byte("c");
		wait_drain();
	endtask

	// End of input at line start flushes; in a body it emits nothing
	task automatic test_end_of_input();
		send_byte(CH_SPACE);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);
		send_byte("k");
		send_item(CH_NEWLINE, 1'b1);
		wait_drain();
	endtask

	// Tie rounds down, and a zero divisor acts as one
	task automatic test_rounding();
		set_scale(2, 1);
		send_byte(CH_SPACE);
		send_byte(CH_SPACE);
		send_byte(CH_SPACE);
		send_byte("b");
		set_scale(0, 3);
		send_byte(CH_TAB);
		send_byte("q");
		wait_drain();
	endtask

	// Largest and smallest scale factors
	task automatic test_extreme_scale();
		set_scale(1, 255);
		send_byte(CH_SPACE);
		send_byte("M");
		set_scale(255, 0);
		send_byte(CH_TAB);
		send_byte(CH_TAB);
		send_byte(CH_NEWLINE);
		wait_drain();
	endtask

	// Tabs and a space past the column limit leave the count saturated
	task automatic test_column_overflow();
		set_scale(1, 1);
		repeat (32) send_byte(CH_TAB);
		send_byte(CH_SPACE);
		send_byte("z");
		wait_drain();
	endtask

	// Pick a scale setting; the extremes come up often
	task automatic random_scale();
		case ($urandom_range(0, 5))
			0: set_scale(1, 255);
			1: set_scale(255, 0);
			2: set_scale(0, $urandom_range(0, 255));
			3: set_scale($urandom_range(1, 8), $urandom_range(1, 8));
			default: set_scale($urandom_range(0, 255), $urandom_range(0, 255));
		endcase
	endtask

	// One line of text, mostly well formed; sometimes noise or a broken line
	task automatic send_random_line(output int sent);
		int          depth;
		int          body_len;
		logic [7:0]  b;
		sent = 0;
		if ($urandom_range(0, 9) == 0) begin
			// Noise: raw bytes with an occasional end of input
			repeat ($urandom_range(1, 4)) begin
				send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
				sent++;
			end
		end else begin
			depth = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36)
				: $urandom_range(0, 4);
			repeat (depth) begin
				send_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
				sent++;
			end
			if ($urandom_range(0, 11) == 0) begin
				// Indentation cut off by end of input
				send_item(8'($urandom_range(0, 255)), 1'b1);
				sent++;
			end else begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_SPACE || b == CH_TAB);
				send_byte(b);
				sent++;
				body_len = $urandom_range(0, 6);
				repeat (body_len) begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == CH_NEWLINE);
					send_byte(b);
					sent++;
				end
				case ($urandom_range(0, 7))
					0: send_item(8'($urandom_range(0, 255)), 1'b1);
					1: ;   // no terminator: next line runs on as body
					default: send_byte(CH_NEWLINE);
				endcase
				sent++;
			end
		end
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		int sent;
		int total;
		int since_cfg;
		src_idle_pct  = idle_pct;
		dst_stall_pct = stall_pct;
		total     = 0;
		since_cfg = 0;
		random_scale();
		while (total < PHASE_ITEMS) begin
			send_random_line(sent);
			total     += sent;
			since_cfg += sent;
			// Pause for the full drain now and then, and change the scale
			if (since_cfg >= 40) begin
				random_scale();
				since_cfg = 0;
			end
		end
		wait_drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		src_valid     = 1'b0;
		src_item      = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		old_step      = 1;
		new_step      = 1;
		in_body       = 1'b0;
		col_cnt       = 0;
		mismatches    = 0;
		src_idle_pct  = 21;
		dst_stall_pct = 66;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pass_through();
		test_start_newline();
		test_end_of_input();
		test_rounding();
		test_extreme_scale();
		test_column_overflow();

		test_random_phase(21, 66);
		test_random_phase(66, 21);
		test_random_phase(0, 0);

		wait_drain();
		if (mismatches == 0 && out_bytes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/irs_pkg.sv
src/irs_front.sv
src/irs_fifo.sv
src/irs_back.sv
src/indentation_rescaler.sv
tb/indentation_rescaler_tb.sv
